// File: rtl/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned ROM_BK_W = 9;
   localparam int unsigned RAM_BK_W = 4;
   localparam int unsigned MAP_W    = 23;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [DATA_W-1:0] RAM_ENABLE_KEY  = 8'h0A;
   localparam logic [DATA_W-1:0] RAM_DISABLE_KEY = 8'h00;
   localparam logic [3:0]        ROM_SIZE_NOWRAP = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CART_TYPE = 2'd0,
      CSR_ROM_SIZE  = 2'd1,
      CSR_RAM_BANKS = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_NONE = 3'd0,
      KIND_MBC1 = 3'd1,
      KIND_MBC2 = 3'd2,
      KIND_MBC3 = 3'd3,
      KIND_MBC5 = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      TGT_FIXED_ROM  = 3'd0,
      TGT_BANKED_ROM = 3'd1,
      TGT_CART_RAM   = 3'd2,
      TGT_FALLBACK   = 3'd3,
      TGT_NOT_CART   = 3'd4,
      TGT_REG_WRITE  = 3'd5
   } target_type;

   typedef struct packed {
      logic [7:0] cart_type;
      logic [3:0] rom_size_code;
      logic [4:0] ram_banks;
   } cfg_type;

   typedef struct packed {
      logic [ROM_BK_W-1:0] rom_bank;
      logic [RAM_BK_W-1:0] ram_bank;
      logic                ram_mode;
      logic                ram_enable;
   } bank_state_type;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] data;
   } access_type;

   typedef struct packed {
      target_type          target;
      logic [MAP_W-1:0]    mapped_address;
      logic [ROM_BK_W-1:0] current_rom_bank;
      logic [RAM_BK_W-1:0] current_ram_bank;
      logic                cart_ram_on;
   } result_type;

   function automatic kind_type cart_kind(input logic [7:0] cart_type);
      kind_type k;
      unique case (cart_type)
         8'h01, 8'h02, 8'h03: k = KIND_MBC1;
         8'h05, 8'h06:        k = KIND_MBC2;
         8'h10, 8'h13:        k = KIND_MBC3;
         8'h19, 8'h1B, 8'h1C: k = KIND_MBC5;
         default:             k = KIND_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [ROM_BK_W-1:0] wrap_bank(input logic [ROM_BK_W-1:0] b,
                                                     input logic [3:0] code);
      logic [ROM_BK_W:0] m;
      if (code >= ROM_SIZE_NOWRAP) begin
         m = {1'b0, {ROM_BK_W{1'b1}}};
      end else begin
         m = ({{ROM_BK_W{1'b0}}, 1'b1} << (code + 4'd1)) - {{ROM_BK_W{1'b0}}, 1'b1};
      end
      return b & m[ROM_BK_W-1:0];
   endfunction

   function automatic logic ram_mapped(input cfg_type cfg, input bank_state_type st);
      kind_type k;
      k = cart_kind(cfg.cart_type);
      return (cfg.ram_banks != 5'd0) &&
             ((k == KIND_MBC1) || ((k == KIND_MBC5) && st.ram_enable));
   endfunction

endpackage

`default_nettype wire

// File: rtl/cbm_req_if.sv
`default_nettype none

interface cbm_req_if;
   import cbm_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [ADDR_W-1:0] req_address;
   logic [DATA_W-1:0] req_data;

   modport source (output valid, output req_type, output req_address, output req_data,
                   input ready);
   modport sink   (input valid, input req_type, input req_address, input req_data,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/cbm_rsp_if.sv
`default_nettype none

interface cbm_rsp_if;
   import cbm_pkg::*;

   logic                valid;
   logic                ready;
   logic [2:0]          rsp_target;
   logic [MAP_W-1:0]    rsp_mapped_address;
   logic [ROM_BK_W-1:0] rsp_current_rom_bank;
   logic [RAM_BK_W-1:0] rsp_current_ram_bank;
   logic                rsp_cart_ram_on;

   modport source (output valid, output rsp_target, output rsp_mapped_address,
                   output rsp_current_rom_bank, output rsp_current_ram_bank,
                   output rsp_cart_ram_on, input ready);
   modport sink   (input valid, input rsp_target, input rsp_mapped_address,
                   input rsp_current_rom_bank, input rsp_current_ram_bank,
                   input rsp_cart_ram_on, output ready);
endinterface

`default_nettype wire

// File: rtl/cbm_bank_regs.sv
`default_nettype none

module cbm_bank_regs
   import cbm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]           csr_wdata,
   input  wire logic                 commit,
   input  wire access_type           access,
   output      cfg_type              cfg,
   output      bank_state_type       bank_cur,
   output      bank_state_type       bank_nxt
);

   cfg_type        cfg_ff;
   cfg_type        cfg_in;
   bank_state_type bank_ff;
   bank_state_type bank_in;
   bank_state_type upd;
   kind_type       kind;
   logic [15:0]    a;
   logic [7:0]     v;
   logic [8:0]     b;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_CART_TYPE: cfg_in.cart_type     = csr_wdata;
            CSR_ROM_SIZE:  cfg_in.rom_size_code = csr_wdata[3:0];
            CSR_RAM_BANKS: cfg_in.ram_banks     = csr_wdata[4:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      kind = cart_kind(cfg_ff.cart_type);
      a    = access.address;
      v    = access.data;
      upd  = bank_ff;
      b    = '0;
      unique case (kind)
         KIND_MBC1: begin
            if (a[15:13] == 3'b001) begin
               b = wrap_bank({1'b0, bank_ff.rom_bank[7:5], v[4:0]}, cfg_ff.rom_size_code);
               upd.rom_bank = (b == 9'd0) ? 9'd1 : b;
            end else if (a[15:13] == 3'b010) begin
               if (!bank_ff.ram_mode) begin
                  upd.rom_bank = wrap_bank({1'b0, v[2:0], bank_ff.rom_bank[4:0]},
                                           cfg_ff.rom_size_code);
               end else if ((v < {3'b000, cfg_ff.ram_banks}) && (v < 8'd16)) begin
                  upd.ram_bank = v[3:0];
               end
            end else if (a[15:13] == 3'b011) begin
               upd.ram_mode = v[0];
            end
         end
         KIND_MBC2: begin
            if (a[15:13] == 3'b001) begin
               upd.rom_bank = wrap_bank({5'b00000, v[3:0]}, cfg_ff.rom_size_code);
            end
         end
         KIND_MBC3: begin
            if (a[15:13] == 3'b001) begin
               b = wrap_bank({2'b00, v[6:0]}, cfg_ff.rom_size_code);
               upd.rom_bank = (b == 9'd0) ? 9'd1 : b;
            end
         end
         KIND_MBC5: begin
            if (a[15:13] == 3'b000) begin
               if (v == RAM_ENABLE_KEY) begin
                  upd.ram_enable = 1'b1;
               end else if (v == RAM_DISABLE_KEY) begin
                  upd.ram_enable = 1'b0;
               end
            end else if (a[15:12] == 4'h2) begin
               upd.rom_bank = wrap_bank({bank_ff.rom_bank[8], v}, cfg_ff.rom_size_code);
            end else if (a[15:12] == 4'h3) begin
               upd.rom_bank = wrap_bank({v[0], bank_ff.rom_bank[7:0]}, cfg_ff.rom_size_code);
            end else if (a[15:13] == 3'b010) begin
               if ({1'b0, v[3:0]} < cfg_ff.ram_banks) begin
                  upd.ram_bank = v[3:0];
               end
            end
         end
         default: upd = bank_ff;
      endcase
      if (!access.req_type || a[15]) begin
         upd = bank_ff;
      end
      bank_in = commit ? upd : bank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= '0;
         bank_ff <= '{rom_bank: 9'd1, ram_bank: 4'd0, ram_mode: 1'b0, ram_enable: 1'b0};
      end else begin
         cfg_ff  <= cfg_in;
         bank_ff <= bank_in;
      end
   end

   assign cfg      = cfg_ff;
   assign bank_cur = bank_ff;
   assign bank_nxt = upd;

endmodule

`default_nettype wire

// File: rtl/cbm_addr_map.sv
`default_nettype none

module cbm_addr_map
   import cbm_pkg::*;
(
   input  wire access_type     access,
   input  wire cfg_type        cfg,
   input  wire bank_state_type bank,
   output      result_type     result
);

   logic [15:0] a;
   logic        ram_on;

   always_comb begin
      a      = access.address;
      ram_on = ram_mapped(cfg, bank);
      result.current_rom_bank = bank.rom_bank;
      result.current_ram_bank = bank.ram_bank;
      result.cart_ram_on      = ram_on;
      if (!a[15]) begin
         if (access.req_type) begin
            result.target         = TGT_REG_WRITE;
            result.mapped_address = {7'd0, a};
         end else if (!a[14]) begin
            result.target         = TGT_FIXED_ROM;
            result.mapped_address = {7'd0, a};
         end else begin
            result.target         = TGT_BANKED_ROM;
            result.mapped_address = {bank.rom_bank, a[13:0]};
         end
      end else if (a[15:13] == 3'b101) begin
         if (ram_on) begin
            result.target         = TGT_CART_RAM;
            result.mapped_address = {6'd0, bank.ram_bank, a[12:0]};
         end else begin
            result.target         = TGT_FALLBACK;
            result.mapped_address = {10'd0, a[12:0]};
         end
      end else begin
         result.target         = TGT_NOT_CART;
         result.mapped_address = {7'd0, a};
      end
   end

endmodule

`default_nettype wire

// File: rtl/cartridge_bank_mapper_top.sv
// An accepted request is held in the input register; its result, mapped from the
// next bank state, moves into the result register once that register is free.
// Throughput: one request per cycle while results are taken; the two registers
// decouple the channels, so a stalled result does not stop acceptance at once.
// Reset is synchronous and active high: ROM bank 1, RAM bank 0, ROM banking mode,
// cartridge RAM disabled, all configuration registers zero, both channels empty.
`default_nettype none

module cartridge_bank_mapper_top
   import cbm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]           csr_wdata,
   cbm_req_if.sink                   req_ch,
   cbm_rsp_if.source                 rsp_ch
);

   logic           s1_valid_ff;
   logic           s1_valid_in;
   access_type     s1_access_ff;
   access_type     s1_access_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   result_type     rsp_ff;
   result_type     rsp_in;
   logic           s1_go;
   logic           req_take;
   cfg_type        cfg;
   bank_state_type bank_cur;
   bank_state_type bank_nxt;
   result_type     result;

   assign s1_go    = s1_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_go;

   cbm_bank_regs u_bank_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .commit    (s1_go),
      .access    (s1_access_ff),
      .cfg       (cfg),
      .bank_cur  (bank_cur),
      .bank_nxt  (bank_nxt)
   );

   cbm_addr_map u_addr_map (
      .access (s1_access_ff),
      .cfg    (cfg),
      .bank   (bank_nxt),
      .result (result)
   );

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_go);
      s1_access_in = req_take ? access_type'{req_type: req_ch.req_type,
                                             address:  req_ch.req_address,
                                             data:     req_ch.req_data}
                              : s1_access_ff;
      rsp_valid_in = s1_go || (rsp_valid_ff && !rsp_ch.ready);
      rsp_in       = s1_go ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_access_ff <= s1_access_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.rsp_target           = rsp_ff.target;
   assign rsp_ch.rsp_mapped_address   = rsp_ff.mapped_address;
   assign rsp_ch.rsp_current_rom_bank = rsp_ff.current_rom_bank;
   assign rsp_ch.rsp_current_ram_bank = rsp_ff.current_ram_bank;
   assign rsp_ch.rsp_cart_ram_on      = rsp_ff.cart_ram_on;

`ifndef ASSERT_OFF
   a_take_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("Accepted request did not reach the input register.");

   a_stage_moves_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid_ff && (rsp_ff == $past(result)))
      else $error("Processed request did not reach the result register.");

   a_cart_ram_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.target == TGT_CART_RAM) |-> rsp_ff.cart_ram_on)
      else $error("Cartridge RAM target without cartridge RAM mapped.");

   a_reg_write_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.target == TGT_REG_WRITE) |-> !rsp_ff.mapped_address[15])
      else $error("Register write reported above the ROM area.");

   a_reset_bank: assert property (@(posedge clock)
      reset |=> (bank_cur.rom_bank == 9'd1) && !bank_cur.ram_enable)
      else $error("Bank state not at its reset value after reset.");
`endif

endmodule

`default_nettype wire

// File: test/bank_map_checker.sv
`default_nettype none

module bank_map_checker
   import cbm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [7:0]           csr_wdata,
   cbm_req_if                        req_ch,
   cbm_rsp_if                        rsp_ch,
   output int unsigned               error_count,
   output int unsigned               compared_count,
   output int unsigned               outstanding
);

   logic [7:0]          cart_type_q;
   logic [3:0]          rom_code_q;
   logic [4:0]          ram_banks_q;
   logic [ROM_BK_W-1:0] rom_bank_q;
   logic [RAM_BK_W-1:0] ram_bank_q;
   logic                ram_mode_q;
   logic                ram_enable_q;

   result_type  expected_maps[$];
   int unsigned mismatches = 0;
   int unsigned compared   = 0;
   int unsigned pending    = 0;

   assign error_count    = mismatches;
   assign compared_count = compared;
   assign outstanding    = pending;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 40) begin
         $display("bank_map_checker: result %0d: %s", compared, msg);
      end
   endtask

   function automatic kind_type mapper_kind(input logic [7:0] ct);
      case (ct)
         8'h01, 8'h02, 8'h03: return KIND_MBC1;
         8'h05, 8'h06:        return KIND_MBC2;
         8'h10, 8'h13:        return KIND_MBC3;
         8'h19, 8'h1B, 8'h1C: return KIND_MBC5;
         default:             return KIND_NONE;
      endcase
   endfunction

   // The bank count is two shifted left by the size code; large codes never wrap.
   function automatic logic [ROM_BK_W-1:0] wrap_rom(input logic [ROM_BK_W-1:0] b);
      logic [ROM_BK_W:0] span;
      if (rom_code_q >= ROM_SIZE_NOWRAP) begin
         return b;
      end
      span = ({{ROM_BK_W{1'b0}}, 1'b1} << (rom_code_q + 4'd1)) - 1'b1;
      return b & span[ROM_BK_W-1:0];
   endfunction

   function automatic logic cart_ram_live();
      kind_type k;
      k = mapper_kind(cart_type_q);
      if (ram_banks_q == 5'd0) begin
         return 1'b0;
      end
      return (k == KIND_MBC1) || ((k == KIND_MBC5) && ram_enable_q);
   endfunction

   function automatic void bank_write(input logic [ADDR_W-1:0] a, input logic [7:0] v);
      logic [ROM_BK_W-1:0] b;
      case (mapper_kind(cart_type_q))
         KIND_MBC1: begin
            if (a >= 16'h2000 && a <= 16'h3FFF) begin
               b = wrap_rom({1'b0, rom_bank_q[7:5], v[4:0]});
               rom_bank_q = (b == '0) ? 9'd1 : b;
            end else if (a >= 16'h4000 && a <= 16'h5FFF) begin
               if (!ram_mode_q) begin
                  rom_bank_q = wrap_rom({1'b0, v[2:0], rom_bank_q[4:0]});
               end else if (v < 8'd16 && v < {3'b000, ram_banks_q}) begin
                  ram_bank_q = v[3:0];
               end
            end else if (a >= 16'h6000) begin
               ram_mode_q = v[0];
            end
         end
         KIND_MBC2: begin
            if (a >= 16'h2000 && a <= 16'h3FFF) begin
               rom_bank_q = wrap_rom({5'b0, v[3:0]});
            end
         end
         KIND_MBC3: begin
            if (a >= 16'h2000 && a <= 16'h3FFF) begin
               b = wrap_rom({2'b0, v[6:0]});
               rom_bank_q = (b == '0) ? 9'd1 : b;
            end
         end
         KIND_MBC5: begin
            if (a <= 16'h1FFF) begin
               if (v == RAM_ENABLE_KEY) begin
                  ram_enable_q = 1'b1;
               end else if (v == RAM_DISABLE_KEY) begin
                  ram_enable_q = 1'b0;
               end
            end else if (a <= 16'h2FFF) begin
               rom_bank_q = wrap_rom({rom_bank_q[8], v});
            end else if (a <= 16'h3FFF) begin
               rom_bank_q = wrap_rom({v[0], rom_bank_q[7:0]});
            end else if (a <= 16'h5FFF) begin
               if ({1'b0, v[3:0]} < ram_banks_q) begin
                  ram_bank_q = v[3:0];
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic result_type map_access(input access_type acc);
      result_type r;
      if (!acc.address[15]) begin
         if (acc.req_type) begin
            bank_write(acc.address, acc.data);
            r.target         = TGT_REG_WRITE;
            r.mapped_address = {7'b0, acc.address};
         end else if (!acc.address[14]) begin
            r.target         = TGT_FIXED_ROM;
            r.mapped_address = {7'b0, acc.address};
         end else begin
            r.target         = TGT_BANKED_ROM;
            r.mapped_address = {rom_bank_q, acc.address[13:0]};
         end
      end else if (acc.address[15:13] == 3'b101) begin
         if (cart_ram_live()) begin
            r.target         = TGT_CART_RAM;
            r.mapped_address = {6'b0, ram_bank_q, acc.address[12:0]};
         end else begin
            r.target         = TGT_FALLBACK;
            r.mapped_address = {10'b0, acc.address[12:0]};
         end
      end else begin
         r.target         = TGT_NOT_CART;
         r.mapped_address = {7'b0, acc.address};
      end
      r.current_rom_bank = rom_bank_q;
      r.current_ram_bank = ram_bank_q;
      r.cart_ram_on      = cart_ram_live();
      return r;
   endfunction

   always @(posedge clock) begin
      result_type want;
      access_type acc;
      if (reset) begin
         cart_type_q  = 8'd0;
         rom_code_q   = 4'd0;
         ram_banks_q  = 5'd0;
         rom_bank_q   = 9'd1;
         ram_bank_q   = 4'd0;
         ram_mode_q   = 1'b0;
         ram_enable_q = 1'b0;
         expected_maps.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CART_TYPE: cart_type_q = csr_wdata;
               CSR_ROM_SIZE:  rom_code_q  = csr_wdata[3:0];
               CSR_RAM_BANKS: ram_banks_q = csr_wdata[4:0];
               default: begin
               end
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            acc.req_type = req_ch.req_type;
            acc.address  = req_ch.req_address;
            acc.data     = req_ch.req_data;
            expected_maps.push_back(map_access(acc));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_maps.size() == 0) begin
               report_mismatch("result arrived with no request outstanding");
            end else begin
               want = expected_maps.pop_front();
               if (rsp_ch.rsp_target !== want.target) begin
                  report_mismatch($sformatf("target %0d, expected %0d",
                                            rsp_ch.rsp_target, want.target));
               end
               if (rsp_ch.rsp_mapped_address !== want.mapped_address) begin
                  report_mismatch($sformatf("mapped address %h, expected %h",
                                            rsp_ch.rsp_mapped_address, want.mapped_address));
               end
               if (rsp_ch.rsp_current_rom_bank !== want.current_rom_bank) begin
                  report_mismatch($sformatf("ROM bank %h, expected %h",
                                            rsp_ch.rsp_current_rom_bank,
                                            want.current_rom_bank));
               end
               if (rsp_ch.rsp_current_ram_bank !== want.current_ram_bank) begin
                  report_mismatch($sformatf("RAM bank %h, expected %h",
                                            rsp_ch.rsp_current_ram_bank,
                                            want.current_ram_bank));
               end
               if (rsp_ch.rsp_cart_ram_on !== want.cart_ram_on) begin
                  report_mismatch($sformatf("cart RAM flag %b, expected %b",
                                            rsp_ch.rsp_cart_ram_on, want.cart_ram_on));
               end
               compared++;
            end
         end
      end
      pending <= expected_maps.size();
   end

endmodule

`default_nettype wire

// File: test/tb_top.sv
`default_nettype none

module tb_top;
   import cbm_pkg::*;

   localparam logic        ACC_READ    = 1'b0;
   localparam logic        ACC_WRITE   = 1'b1;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SEGMENTS    = 14;
   localparam int unsigned SEG_ITEMS   = 125;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   csr_index_type        csr_index;
   logic [7:0]           csr_wdata;

   int unsigned send_idle_pct = 31;
   int unsigned rsp_idle_pct  = 54;
   int unsigned hold_asks     = 0;
   int unsigned requests_sent = 0;
   int unsigned settings_used = 0;
   int unsigned cycles        = 0;

   int unsigned error_count;
   int unsigned compared_count;
   int unsigned outstanding;

   cbm_req_if req_ch ();
   cbm_rsp_if rsp_ch ();

   cartridge_bank_mapper_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   bank_map_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .error_count    (error_count),
      .compared_count (compared_count),
      .outstanding    (outstanding)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // A long hold-off is requested by bumping hold_asks; it is counted down here.
   initial begin
      int unsigned served;
      int unsigned stall_left;
      served     = 0;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != served) begin
            served     = hold_asks;
            stall_left = 80;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_access(input logic kind, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= kind;
      req_ch.req_address <= addr;
      req_ch.req_data    <= value;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic program_mapper(input logic [7:0] ct, input logic [3:0] code,
                                 input logic [4:0] banks);
      csr_we    <= 1'b1;
      csr_index <= CSR_CART_TYPE;
      csr_wdata <= ct;
      @(posedge clock);
      csr_index <= CSR_ROM_SIZE;
      csr_wdata <= {4'b0, code};
      @(posedge clock);
      csr_index <= CSR_RAM_BANKS;
      csr_wdata <= {3'b0, banks};
      @(posedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Most requests hit a live window, and register writes mostly carry data that the bank registers care about.
   function automatic access_type random_access();
      access_type acc;
      int unsigned r;
      acc.req_type = 1'($urandom_range(1));
      acc.address  = 16'($urandom_range(16'hFFFF));
      acc.data     = 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 30) begin
         acc.req_type    = ACC_WRITE;
         acc.address[15] = 1'b0;
         r = $urandom_range(99);
         if (r < 25) begin
            acc.data = RAM_ENABLE_KEY;
         end else if (r < 35) begin
            acc.data = RAM_DISABLE_KEY;
         end else if (r < 60) begin
            acc.data = 8'($urandom_range(20));
         end
      end else if (r < 55) begin
         acc.req_type       = ACC_READ;
         acc.address[15:14] = 2'b01;
      end else if (r < 75) begin
         acc.address[15:13] = 3'b101;
      end else if (r < 85) begin
         acc.req_type       = ACC_READ;
         acc.address[15:14] = 2'b00;
      end
      return acc;
   endfunction

   initial begin
      logic [7:0]  cart_list [SEGMENTS];
      logic [4:0]  banks;
      access_type  acc;
      cart_list = '{8'h01, 8'h19, 8'h13, 8'h05, 8'h00, 8'h1C, 8'h02,
                    8'h10, 8'h1B, 8'h06, 8'h03, 8'hFF, 8'h47, 8'h19};
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= ACC_READ;
      req_ch.req_address <= '0;
      req_ch.req_data    <= '0;
      csr_we             <= 1'b0;
      csr_index          <= CSR_CART_TYPE;
      csr_wdata          <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_mapper(8'h19, 4'd8, 5'd16);
      send_access(ACC_READ,  16'h0000, 8'h00);
      send_access(ACC_READ,  16'h3FFF, 8'hFF);
      send_access(ACC_READ,  16'h4000, 8'h00);
      send_access(ACC_WRITE, 16'h0000, RAM_ENABLE_KEY);
      send_access(ACC_READ,  16'hA000, 8'h00);
      send_access(ACC_WRITE, 16'h2000, 8'hFF);
      send_access(ACC_WRITE, 16'h3000, 8'h01);
      send_access(ACC_READ,  16'h7FFF, 8'h00);
      send_access(ACC_WRITE, 16'h4000, 8'h0F);
      send_access(ACC_READ,  16'hBFFF, 8'h00);
      send_access(ACC_WRITE, 16'h1FFF, RAM_DISABLE_KEY);
      send_access(ACC_READ,  16'hBFFF, 8'h00);
      send_access(ACC_READ,  16'h8000, 8'h00);
      send_access(ACC_WRITE, 16'hFFFF, 8'hFF);
      wait_for_results();

      // Bank zero turns into one, and a RAM bank beyond the fitted count is ignored.
      program_mapper(8'h01, 4'd0, 5'd4);
      send_access(ACC_WRITE, 16'h2000, 8'h00);
      send_access(ACC_WRITE, 16'h4000, 8'h07);
      send_access(ACC_WRITE, 16'h6000, 8'h01);
      send_access(ACC_WRITE, 16'h4000, 8'h03);
      send_access(ACC_WRITE, 16'h4000, 8'h04);
      send_access(ACC_READ,  16'hA123, 8'h00);
      wait_for_results();

      program_mapper(8'h13, 4'd2, 5'd0);
      send_access(ACC_WRITE, 16'h2000, 8'h80);
      send_access(ACC_WRITE, 16'h3FFF, 8'h7F);
      send_access(ACC_READ,  16'h7FFF, 8'h00);
      send_access(ACC_READ,  16'hA000, 8'h00);

      for (int unsigned s = 0; s < SEGMENTS; s++) begin
         wait_for_results();
         case (s % 3)
            0:       banks = 5'd16;
            1:       banks = 5'($urandom_range(16, 1));
            default: banks = 5'd0;
         endcase
         program_mapper(cart_list[s], (s == 0) ? 4'd0 : (s == 1) ? 4'd8 :
                        4'($urandom_range(8)), banks);
         if (s < 5) begin
            send_idle_pct = 31;
            rsp_idle_pct  = 54;
         end else if (s < 10) begin
            send_idle_pct = 54;
            rsp_idle_pct  = 31;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
         end
         if (s == 10 || s == 12) begin
            hold_asks++;
         end
         for (int unsigned n = 0; n < SEG_ITEMS; n++) begin
            acc = random_access();
            send_access(acc.req_type, acc.address, acc.data);
         end
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      $display("tb_top: %0d requests over %0d mapper settings, %0d results compared,",
               requests_sent, settings_used, compared_count);
      $display("tb_top: both channels idled in turn and the result side was held off twice");
      if (error_count == 0 && outstanding == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
